// ----- rtl/cocnt_pkg.sv -----
// Shared constants, register indexes and controller/datapath interface types.
package cocnt_pkg;

   localparam int LABEL_BITS  = 15;
   localparam int LABEL_COUNT = 1 << LABEL_BITS;
   localparam int COL_BITS    = 12;
   localparam int MAX_WIDTH   = 1 << COL_BITS;
   localparam int WIDTH_BITS  = COL_BITS + 1;
   localparam int ROW_BITS    = 16;
   localparam int COUNT_BITS  = 15;
   localparam int CAND_COUNT  = 5;
   localparam int STEP_BITS   = 3;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [ROW_BITS-1:0]   ROW_MAX   = '1;
   localparam logic [ROW_BITS-1:0]   ROW_WRAP  = ROW_BITS'(2);
   localparam logic [LABEL_BITS-1:0] FIRST_CLUSTER = LABEL_BITS'(2);
   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = WIDTH_BITS'(MAX_WIDTH);
   localparam logic [WIDTH_BITS-1:0] WIDTH_MIN = WIDTH_BITS'(1);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_MATCH_MODE  = CSR_INDEX_BITS'(1);

   localparam logic MODE_TOUCH   = 1'b0;
   localparam logic MODE_OVERLAP = 1'b1;

   // Line-buffer read steps; the last step only collects data.
   localparam logic [STEP_BITS-1:0] STEP_UP      = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] STEP_UPRIGHT = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] STEP_UPLEFT  = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] STEP_LEFT    = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] STEP_LAST    = STEP_BITS'(4);

   typedef struct packed {
      logic                  accept;
      logic                  rd_active;
      logic [STEP_BITS-1:0]  rd_step;
      logic                  eval;
      logic                  mread;
      logic                  mwrite;
      logic                  commit;
      logic                  load_rsp;
      logic                  clr_en;
      logic [LABEL_BITS-1:0] clr_addr;
   } cmd_type;

   typedef struct packed {
      logic cand_pending;
      logic last;
      logic rsp_free;
   } stat_type;

endpackage

// ----- rtl/cocnt_ctrl.sv -----
// Sequencer: pixel reads, evaluation, matching, commit, result load, table sweep.
module cocnt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cocnt_pkg::stat_type stat,
   output cocnt_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_EVAL   = 3'd3;
   localparam logic [2:0] ST_MREAD  = 3'd4;
   localparam logic [2:0] ST_MWRITE = 3'd5;
   localparam logic [2:0] ST_COMMIT = 3'd6;
   localparam logic [2:0] ST_RESULT = 3'd7;

   logic [2:0]                          state_ff, state_in;
   logic [cocnt_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic [cocnt_pkg::LABEL_BITS-1:0]    clr_ff, clr_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      cmd      = '0;
      cmd.rd_step  = step_ff;
      cmd.clr_addr = clr_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_active = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == cocnt_pkg::STEP_LAST) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_MREAD;
         end
         ST_MREAD: begin
            if (stat.cand_pending) begin
               cmd.mread = 1'b1;
               state_in = ST_MWRITE;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_MWRITE: begin
            cmd.mwrite = 1'b1;
            state_in = ST_MREAD;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = stat.last ? ST_RESULT : ST_IDLE;
         end
         ST_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               clr_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         clr_ff   <= clr_in;
      end
   end

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.rsp_free)
      else $error("Result loaded while the output register is still occupied.");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.rd_active, cmd.eval, cmd.mread, cmd.mwrite,
                cmd.commit, cmd.load_rsp, cmd.clr_en}))
      else $error("More than one sequencer command in a cycle.");
   a_accept_step: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (cmd.rd_active && step_ff == cocnt_pkg::STEP_UP))
      else $error("Read sequence did not start after a transfer.");
`endif

endmodule

// ----- rtl/cocnt_dp.sv -----
// Datapath: label tables, line buffers, counters, position tracking and output register.
module cocnt_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cocnt_pkg::cmd_type                     cmd,
   output cocnt_pkg::stat_type                    stat,
   input  logic                                   csr_write_enable,
   input  logic [cocnt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cocnt_pkg::WIDTH_BITS-1:0]       csr_write_data,
   input  logic [cocnt_pkg::LABEL_BITS-1:0]       req_truth_label,
   input  logic [cocnt_pkg::LABEL_BITS-1:0]       req_change_label,
   input  logic                                   req_final_pixel,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [cocnt_pkg::COUNT_BITS-1:0]       rsp_truth_clusters,
   output logic [cocnt_pkg::COUNT_BITS-1:0]       rsp_change_clusters,
   output logic [cocnt_pkg::COUNT_BITS-1:0]       rsp_matched_clusters
);

   localparam int LB = cocnt_pkg::LABEL_BITS;
   localparam int CB = cocnt_pkg::COL_BITS;
   localparam int WB = cocnt_pkg::WIDTH_BITS;
   localparam int NB = cocnt_pkg::COUNT_BITS;
   localparam int NC = cocnt_pkg::CAND_COUNT;

   // Memories.
   logic          truth_pres_mem [cocnt_pkg::LABEL_COUNT];
   logic          chg_pres_mem   [cocnt_pkg::LABEL_COUNT];
   logic          match_mem      [cocnt_pkg::LABEL_COUNT];
   logic [LB-1:0] line_mem       [cocnt_pkg::MAX_WIDTH];
   logic          chg_row_mem    [2 * cocnt_pkg::MAX_WIDTH];

   logic          truth_pres_q, chg_pres_q, match_q, chg_row_q;
   logic [LB-1:0] line_q;

   // Configuration.
   logic [WB-1:0] width_ff;
   logic          mode_ff;

   // Pixel context.
   logic [LB-1:0] t_ff, c_ff;
   logic          last_ff;
   logic [CB-1:0] x_ff, col_ff;
   logic [cocnt_pkg::ROW_BITS-1:0] row_ff;
   logic          has_up_ff, has_left_ff, has_right_ff, par_ff;
   logic [LB-1:0] up_ff, ur_ff, lt_ff, ul_ff;
   logic          nu_ff, nur_ff, nul_ff, nlc_ff, tp_ff, cp_ff;
   logic [NC-1:0] cand_ff;
   logic [NB-1:0] tcnt_ff, ccnt_ff, mcnt_ff;
   logic          rsp_valid_ff;
   logic [NB-1:0] rsp_t_ff, rsp_c_ff, rsp_m_ff;

   // Accept-time position decode.
   logic [WB-1:0] w_eff;
   logic [CB-1:0] x_in;
   logic          has_right_in;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = cocnt_pkg::WIDTH_MIN;
      end else if (width_ff > cocnt_pkg::WIDTH_MAX) begin
         w_eff = cocnt_pkg::WIDTH_MAX;
      end else begin
         w_eff = width_ff;
      end
      if ({1'b0, col_ff} >= w_eff) begin
         x_in = CB'(w_eff - 1'b1);
      end else begin
         x_in = col_ff;
      end
      has_right_in = ({1'b0, x_in} + 1'b1) < w_eff;
   end

   // Read addressing for the line buffers.
   logic [CB-1:0] x_p1, x_m1, line_addr;
   logic [CB:0]   row_addr;
   logic          lb_rd;

   always_comb begin
      x_p1 = x_ff + 1'b1;
      x_m1 = x_ff - 1'b1;
      unique case (cmd.rd_step)
         cocnt_pkg::STEP_UP: begin
            line_addr = x_ff;
            row_addr  = {~par_ff, x_ff};
         end
         cocnt_pkg::STEP_UPRIGHT: begin
            line_addr = x_p1;
            row_addr  = {~par_ff, x_p1};
         end
         cocnt_pkg::STEP_UPLEFT: begin
            line_addr = x_m1;
            row_addr  = {~par_ff, x_m1};
         end
         default: begin
            line_addr = x_m1;
            row_addr  = {par_ff, x_m1};
         end
      endcase
      lb_rd = cmd.rd_active && (cmd.rd_step != cocnt_pkg::STEP_LAST);
   end

   // Evaluation of the neighbourhood.
   logic          t_nz, c_nz, any_chg;
   logic [NC-1:0] cand_in;

   always_comb begin
      t_nz = t_ff != '0;
      c_nz = c_ff != '0;
      any_chg = c_nz || nlc_ff || nu_ff || nul_ff || nur_ff;
      cand_in = '0;
      if (mode_ff == cocnt_pkg::MODE_OVERLAP) begin
         cand_in[0] = t_nz && c_nz;
      end else begin
         cand_in[0] = t_nz && any_chg;
         cand_in[1] = c_nz && (lt_ff != '0);
         cand_in[2] = c_nz && (up_ff != '0);
         cand_in[3] = c_nz && has_up_ff && has_left_ff && (ul_ff != '0);
         cand_in[4] = c_nz && (ur_ff != '0);
      end
   end

   // Lowest pending candidate.
   logic [LB-1:0] sel_label;

   always_comb begin
      priority if (cand_ff[0]) begin
         sel_label = t_ff;
      end else if (cand_ff[1]) begin
         sel_label = lt_ff;
      end else if (cand_ff[2]) begin
         sel_label = up_ff;
      end else if (cand_ff[3]) begin
         sel_label = ul_ff;
      end else begin
         sel_label = ur_ff;
      end
   end

   logic truth_new, chg_new, match_new;

   assign truth_new = cmd.eval && (t_ff >= cocnt_pkg::FIRST_CLUSTER) && !tp_ff;
   assign chg_new   = cmd.eval && (c_ff >= cocnt_pkg::FIRST_CLUSTER) && !cp_ff;
   assign match_new = cmd.mwrite && !match_q;

   // Label tables: cleared by sweep, set on first sight.
   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         truth_pres_mem[cmd.clr_addr] <= 1'b0;
      end else if (truth_new) begin
         truth_pres_mem[t_ff] <= 1'b1;
      end
      if (cmd.rd_active && cmd.rd_step == cocnt_pkg::STEP_UP) begin
         truth_pres_q <= truth_pres_mem[t_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         chg_pres_mem[cmd.clr_addr] <= 1'b0;
      end else if (chg_new) begin
         chg_pres_mem[c_ff] <= 1'b1;
      end
      if (cmd.rd_active && cmd.rd_step == cocnt_pkg::STEP_UP) begin
         chg_pres_q <= chg_pres_mem[c_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_en) begin
         match_mem[cmd.clr_addr] <= 1'b0;
      end else if (match_new) begin
         match_mem[sel_label] <= 1'b1;
      end
      if (cmd.mread) begin
         match_q <= match_mem[sel_label];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         line_mem[x_ff] <= t_ff;
      end
      if (lb_rd) begin
         line_q <= line_mem[line_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         chg_row_mem[{par_ff, x_ff}] <= c_nz;
      end
      if (lb_rd) begin
         chg_row_q <= chg_row_mem[row_addr];
      end
   end

   // Payload registers of the pixel in flight.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         t_ff         <= req_truth_label;
         c_ff         <= req_change_label;
         last_ff      <= req_final_pixel;
         x_ff         <= x_in;
         has_up_ff    <= row_ff != '0;
         has_left_ff  <= x_in != '0;
         has_right_ff <= has_right_in;
         par_ff       <= row_ff[0];
      end
      // Every step after the first collects the data of the read issued one step earlier.
      if (cmd.rd_active) begin
         unique case (cmd.rd_step)
            cocnt_pkg::STEP_UPRIGHT: begin
               up_ff <= has_up_ff ? line_q : '0;
               nu_ff <= has_up_ff && chg_row_q;
               tp_ff <= truth_pres_q;
               cp_ff <= chg_pres_q;
            end
            cocnt_pkg::STEP_UPLEFT: begin
               ur_ff  <= (has_up_ff && has_right_ff) ? line_q : '0;
               nur_ff <= has_up_ff && has_right_ff && chg_row_q;
            end
            cocnt_pkg::STEP_LEFT: begin
               lt_ff  <= has_left_ff ? line_q : '0;
               nul_ff <= has_up_ff && has_left_ff && chg_row_q;
            end
            cocnt_pkg::STEP_LAST: begin
               nlc_ff <= has_left_ff && chg_row_q;
            end
            default: begin
            end
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_t_ff <= tcnt_ff;
         rsp_c_ff <= ccnt_ff;
         rsp_m_ff <= mcnt_ff;
      end
   end

   // Control state: configuration, positions, counts, candidates, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= cocnt_pkg::WIDTH_MIN;
         mode_ff      <= cocnt_pkg::MODE_TOUCH;
         col_ff       <= '0;
         row_ff       <= '0;
         ul_ff        <= '0;
         tcnt_ff      <= '0;
         ccnt_ff      <= '0;
         mcnt_ff      <= '0;
         cand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == cocnt_pkg::REG_IMAGE_WIDTH) begin
               width_ff <= csr_write_data;
            end else if (csr_index == cocnt_pkg::REG_MATCH_MODE) begin
               mode_ff <= csr_write_data[0];
            end
         end
         if (truth_new && tcnt_ff != cocnt_pkg::COUNT_MAX) begin
            tcnt_ff <= tcnt_ff + 1'b1;
         end
         if (chg_new && ccnt_ff != cocnt_pkg::COUNT_MAX) begin
            ccnt_ff <= ccnt_ff + 1'b1;
         end
         if (match_new && mcnt_ff != cocnt_pkg::COUNT_MAX) begin
            mcnt_ff <= mcnt_ff + 1'b1;
         end
         if (cmd.eval) begin
            cand_ff <= cand_in;
         end else if (cmd.mwrite) begin
            cand_ff <= cand_ff & (cand_ff - 1'b1);
         end
         if (cmd.commit) begin
            if (!has_right_ff) begin
               col_ff <= '0;
               ul_ff  <= '0;
               row_ff <= (row_ff != cocnt_pkg::ROW_MAX) ? row_ff + 1'b1
                                                         : cocnt_pkg::ROW_WRAP;
            end else begin
               col_ff <= x_p1;
               ul_ff  <= up_ff;
            end
         end
         if (cmd.load_rsp) begin
            tcnt_ff <= '0;
            ccnt_ff <= '0;
            mcnt_ff <= '0;
            col_ff  <= '0;
            row_ff  <= '0;
            ul_ff   <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.cand_pending = cand_ff != '0;
   assign stat.last         = last_ff;
   assign stat.rsp_free     = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_truth_clusters   = rsp_t_ff;
   assign rsp_change_clusters  = rsp_c_ff;
   assign rsp_matched_clusters = rsp_m_ff;

`ifndef SYNTHESIS
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> (rsp_valid_ff && tcnt_ff == '0 && mcnt_ff == '0))
      else $error("Result load did not raise valid and clear the counts.");
   a_mread_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.mread |-> (cand_ff != '0))
      else $error("Match table read without a pending candidate.");
   a_cand_shrink: assert property (@(posedge clock) disable iff (reset)
      cmd.mwrite |=> ($countones(cand_ff) < $countones($past(cand_ff))))
      else $error("Candidate mask did not shrink after a match update.");
`endif

endmodule

// ----- rtl/cluster_overlap_counter_unit.sv -----
// A pixel steps through accept, line-buffer reads, evaluation, a match read and commit before
// the next transfer; each label to mark matched (up to 5 in touch mode) adds a match read and
// write; one port per table sets this. After the final pixel commits, the result is loaded
// once the output register is free; the label tables are then swept clear, with input stalled.
// Reset is synchronous; it is followed by the same clearing sweep.
// Configuration writes are taken in any cycle.
module cluster_overlap_counter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [cocnt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cocnt_pkg::WIDTH_BITS-1:0]     csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cocnt_pkg::LABEL_BITS-1:0]     req_truth_label,
   input  logic [cocnt_pkg::LABEL_BITS-1:0]     req_change_label,
   input  logic                                 req_final_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cocnt_pkg::COUNT_BITS-1:0]     rsp_truth_clusters,
   output logic [cocnt_pkg::COUNT_BITS-1:0]     rsp_change_clusters,
   output logic [cocnt_pkg::COUNT_BITS-1:0]     rsp_matched_clusters
);

   cocnt_pkg::cmd_type  cmd;
   cocnt_pkg::stat_type stat;

   cocnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cocnt_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_truth_label      (req_truth_label),
      .req_change_label     (req_change_label),
      .req_final_pixel      (req_final_pixel),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_truth_clusters   (rsp_truth_clusters),
      .rsp_change_clusters  (rsp_change_clusters),
      .rsp_matched_clusters (rsp_matched_clusters)
   );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the cluster overlap counter: directed, pressure and random images.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 150000;
   localparam int LONG_HOLD   = 40000;
   localparam int ITEM_TARGET = 1950;

   typedef logic [cocnt_pkg::LABEL_BITS-1:0]     label_type;
   typedef logic [cocnt_pkg::COUNT_BITS-1:0]     count_type;
   typedef logic [cocnt_pkg::CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [cocnt_pkg::WIDTH_BITS-1:0]     csr_data_type;
   typedef logic [cocnt_pkg::COL_BITS-1:0]       col_type;
   typedef logic [cocnt_pkg::COL_BITS:0]         row_slot_type;

   // Indexes beyond the two registers; writes to them must be ignored.
   localparam csr_index_type REG_UNMAPPED_LO = csr_index_type'(2);
   localparam csr_index_type REG_UNMAPPED_HI = csr_index_type'(3);

   typedef struct {
      count_type truth;
      count_type change;
      count_type matched;
   } cluster_counts_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   csr_index_type csr_index = '0;
   csr_data_type csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   label_type req_truth_label = '0;
   label_type req_change_label = '0;
   logic req_final_pixel = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   count_type rsp_truth_clusters;
   count_type rsp_change_clusters;
   count_type rsp_matched_clusters;

   cluster_overlap_counter_unit i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state.
   bit truth_seen [cocnt_pkg::LABEL_COUNT];
   bit change_seen [cocnt_pkg::LABEL_COUNT];
   bit truth_hit [cocnt_pkg::LABEL_COUNT];
   count_type truth_total, change_total, hit_total;
   label_type row_truth [cocnt_pkg::MAX_WIDTH];
   bit row_change [2*cocnt_pkg::MAX_WIDTH];
   label_type upleft_truth;
   int unsigned col_pos, row_pos;
   int unsigned cfg_width;
   bit cfg_mode;

   cluster_counts_type expected_counts [$];
   int errors = 0;
   int pixels_sent = 0;
   bit quiet = 1'b0;
   bit long_hold = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;

   function automatic void clear_counts();
      truth_seen = '{default: 1'b0};
      change_seen = '{default: 1'b0};
      truth_hit = '{default: 1'b0};
      truth_total = '0;
      change_total = '0;
      hit_total = '0;
      upleft_truth = '0;
      col_pos = 0;
      row_pos = 0;
   endfunction

   function automatic void mark_hit(label_type lbl);
      if (lbl != 0 && !truth_hit[lbl]) begin
         truth_hit[lbl] = 1;
         if (hit_total != cocnt_pkg::COUNT_MAX) hit_total++;
      end
   endfunction

   function automatic void count_pixel(label_type t, label_type c, logic last);
      int unsigned w, x, cur, prv;
      bit has_up, has_left, has_right, any;
      label_type up_t, ul_t, ur_t, left_t;
      cluster_counts_type res;
      w = cfg_width;
      if (w == 0) w = 1;
      if (w > cocnt_pkg::MAX_WIDTH) w = cocnt_pkg::MAX_WIDTH;
      x = col_pos;
      if (x >= w) x = w - 1;
      has_up = row_pos != 0;
      has_left = x != 0;
      has_right = x + 1 < w;
      cur = row_pos[0] ? cocnt_pkg::MAX_WIDTH : 0;
      prv = cocnt_pkg::MAX_WIDTH - cur;
      if (t >= cocnt_pkg::FIRST_CLUSTER && !truth_seen[t]) begin
         truth_seen[t] = 1;
         if (truth_total != cocnt_pkg::COUNT_MAX) truth_total++;
      end
      if (c >= cocnt_pkg::FIRST_CLUSTER && !change_seen[c]) begin
         change_seen[c] = 1;
         if (change_total != cocnt_pkg::COUNT_MAX) change_total++;
      end
      up_t = has_up ? row_truth[col_type'(x)] : '0;
      ul_t = upleft_truth;
      ur_t = (has_up && has_right) ? row_truth[col_type'(x + 1)] : '0;
      left_t = has_left ? row_truth[col_type'(x - 1)] : '0;
      if (cfg_mode == cocnt_pkg::MODE_OVERLAP) begin
         if (t != 0 && c != 0) mark_hit(t);
      end else begin
         any = c != 0;
         if (has_left && row_change[row_slot_type'(cur + x - 1)]) any = 1;
         if (has_up) begin
            if (row_change[row_slot_type'(prv + x)]) any = 1;
            if (has_left && row_change[row_slot_type'(prv + x - 1)]) any = 1;
            if (has_right && row_change[row_slot_type'(prv + x + 1)]) any = 1;
         end
         if (t != 0 && any) mark_hit(t);
         if (c != 0) begin
            if (has_left) mark_hit(left_t);
            if (has_up) begin
               mark_hit(up_t);
               if (has_left) mark_hit(ul_t);
               if (has_right) mark_hit(ur_t);
            end
         end
      end
      upleft_truth = up_t;
      row_truth[col_type'(x)] = t;
      row_change[row_slot_type'(cur + x)] = c != 0;
      if (x + 1 >= w) begin
         col_pos = 0;
         upleft_truth = '0;
         if (row_pos < 16'hFFFF) row_pos++;
         else row_pos = 2;
      end else begin
         col_pos = x + 1;
      end
      if (last) begin
         res.truth = truth_total;
         res.change = change_total;
         res.matched = hit_total;
         expected_counts.push_back(res);
         clear_counts();
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 70) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 20);
   endfunction

   task automatic send_pixel(label_type t, label_type c, logic last);
      int gap;
      req_truth_label <= t;
      req_change_label <= c;
      req_final_pixel <= last;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      count_pixel(t, c, last);
      pixels_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(csr_index_type idx, csr_data_type data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == cocnt_pkg::REG_IMAGE_WIDTH) cfg_width = 32'(data);
      else if (idx == cocnt_pkg::REG_MATCH_MODE) cfg_mode = data[0];
   endtask

   // Configuration changes only once every result is in and the last pixel has drained.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic test_directed_extremes();
      write_reg(cocnt_pkg::REG_IMAGE_WIDTH, '0);
      send_pixel(15'h7FFF, 15'h0000, 1'b0);
      send_pixel(15'h0000, 15'h7FFF, 1'b0);
      send_pixel(15'd1, 15'd0, 1'b0);
      send_pixel(15'd2, 15'd2, 1'b1);
      wait_drained();
      write_reg(cocnt_pkg::REG_IMAGE_WIDTH, 13'd3);
      write_reg(cocnt_pkg::REG_MATCH_MODE, csr_data_type'(cocnt_pkg::MODE_OVERLAP));
      send_pixel(15'd3, 15'd0, 1'b0);
      send_pixel(15'd3, 15'd4, 1'b0);
      send_pixel(15'd0, 15'd0, 1'b0);
      send_pixel(15'd4, 15'd0, 1'b0);
      send_pixel(15'd1, 15'd1, 1'b1);
      wait_drained();
      write_reg(cocnt_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
      write_reg(cocnt_pkg::REG_MATCH_MODE, csr_data_type'(cocnt_pkg::MODE_TOUCH));
      write_reg(REG_UNMAPPED_LO, 13'h0AAA);
      write_reg(REG_UNMAPPED_HI, 13'h1555);
      send_pixel(15'd2, 15'd0, 1'b0);
      send_pixel(15'd0, 15'd9, 1'b0);
      send_pixel(15'd2, 15'd0, 1'b1);
      wait_drained();
      write_reg(cocnt_pkg::REG_IMAGE_WIDTH, cocnt_pkg::WIDTH_MAX);
      write_reg(cocnt_pkg::REG_MATCH_MODE, csr_data_type'(cocnt_pkg::MODE_OVERLAP));
      send_pixel(15'h5555, 15'h2AAA, 1'b0);
      send_pixel(15'h2AAA, 15'h5555, 1'b1);
      wait_drained();
   endtask

   function automatic label_type pick_label(int unsigned base, int unsigned span);
      int r;
      r = $urandom_range(99);
      if (r < 35) return '0;
      if (r < 45) return label_type'($urandom());
      if (r < 50) return label_type'(1);
      return label_type'(base + $urandom_range(span));
   endfunction

   task automatic send_image(int unsigned npix);
      int unsigned base, span;
      base = $urandom_range(2) == 0 ? $urandom_range(32000) : 2;
      span = $urandom_range(8, 1);
      for (int unsigned i = 0; i < npix; i++)
         send_pixel(pick_label(base, span), pick_label(base, span), i == npix - 1);
   endtask

   // The receiver holds off while two images go in, so the second final pixel backs up.
   task automatic test_pressure();
      write_reg(cocnt_pkg::REG_IMAGE_WIDTH, 13'd4);
      write_reg(cocnt_pkg::REG_MATCH_MODE, csr_data_type'(cocnt_pkg::MODE_TOUCH));
      long_hold = 1'b1;
      send_image(12);
      send_image(9);
      wait_drained();
   endtask

   task automatic test_random_images();
      while (pixels_sent < ITEM_TARGET) begin
         if ($urandom_range(9) == 0)
            write_reg(cocnt_pkg::REG_IMAGE_WIDTH, csr_data_type'($urandom_range(64, 13)));
         else
            write_reg(cocnt_pkg::REG_IMAGE_WIDTH, csr_data_type'($urandom_range(12, 1)));
         write_reg(cocnt_pkg::REG_MATCH_MODE, csr_data_type'($urandom_range(1)));
         quiet = $urandom_range(3) == 0;
         send_image($urandom_range(150, 10));
         wait_drained();
      end
      quiet = 1'b0;
   endtask

   always @(posedge clock) begin
      if (long_hold) begin
         rsp_stall <= 1'b1;
         stall_left++;
         if (stall_left >= LONG_HOLD) begin
            long_hold = 1'b0;
            stall_left = 0;
         end
      end else if (stall_left > 0) begin
         stall_left--;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= $urandom_range(3) == 0;
         stall_left = $urandom_range(19) == 0 ? $urandom_range(50, 10) : $urandom_range(2);
      end
   end

   always @(posedge clock) begin
      cluster_counts_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected result %0d %0d %0d", rsp_truth_clusters,
                                       rsp_change_clusters, rsp_matched_clusters);
         end else begin
            want = expected_counts.pop_front();
            if (rsp_truth_clusters !== want.truth || rsp_change_clusters !== want.change ||
                rsp_matched_clusters !== want.matched) begin
               errors++;
               if (errors <= 10)
                  $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d", want.truth,
                           want.change, want.matched, rsp_truth_clusters,
                           rsp_change_clusters, rsp_matched_clusters);
            end
         end
      end
   end

   // Watchdog: cycles in which no transfer happens on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      cfg_width = 1;
      cfg_mode = cocnt_pkg::MODE_TOUCH;
      clear_counts();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_pressure();
      test_random_images();
      repeat (50) @(posedge clock);
      if (expected_counts.size() != 0) errors++;
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ----- files.f -----
rtl/cocnt_pkg.sv
rtl/cocnt_ctrl.sv
rtl/cocnt_dp.sv
rtl/cluster_overlap_counter_unit.sv
tb/tb.sv
